>>> src/clnf_pkg.sv
// ----------------------------------------------------------------------------
// clnf_pkg
// Shared types, codes and helpers for the character LCD number formatter.
// ----------------------------------------------------------------------------
package clnf_pkg;

    localparam int DEF_VALUE_WIDTH = 16;
    localparam int DEF_MAX_DIGITS  = 16;

    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] LINE2_OFFSET  = 8'h40;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_PLUS    = 8'h2B;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;

    localparam logic [1:0] LINE_TOP = 2'd1;

    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_SDEC = 3'd2;
    localparam logic [2:0] KIND_HEX  = 3'd3;
    localparam logic [2:0] KIND_BIN  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_CHAR,
        ST_SIGN,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < 4'd10)
        begin
            return ASCII_ZERO + d8;
        end
        return ASCII_UPPER_A + d8 - 8'd10;
    endfunction

endpackage

>>> src/char_lcd_number_formatter.sv
// ----------------------------------------------------------------------------
// char_lcd_number_formatter
// Turns one display request into a cursor command and ASCII data bytes.
// ----------------------------------------------------------------------------
// Steps: the request word is registered, the cursor command is queued, then a char
// request queues its byte; numeric requests queue a sign if signed, convert the value
// in the bit-serial binary-to-BCD shift register, align it in the digit align shifter and emit digits.
// One request at a time; the next word is taken as soon as the last byte is queued.
// Reset (rst_n low, asynchronous) returns to idle and empties the output register.
// ----------------------------------------------------------------------------
module char_lcd_number_formatter
    import clnf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // line[1:0], column[7:2], value[23:8], digits[28:24]
    input  logic [2:0]  s_axis_tuser,  // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tuser,  // is_data[0]
    output logic        m_axis_tlast
);

    localparam int BUF_W = 4 * MAX_DIGITS;
    localparam int DIG_W = $clog2(MAX_DIGITS + 1);
    localparam int CNT_MAX = (VALUE_WIDTH > MAX_DIGITS) ? VALUE_WIDTH : MAX_DIGITS;
    localparam int CNT_W = $clog2(CNT_MAX + 1);

    logic [1:0]  in_line;
    logic [5:0]  in_column;
    logic [15:0] in_value;
    logic [4:0]  in_digits;
    logic        s_acc;

    logic [VALUE_WIDTH-1:0] val_w;
    logic                   val_neg;
    logic [7:0]             cmd_byte;
    logic [DIG_W-1:0]       ndig_in;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BUF_W-1:0]       buf_reg, buf_next;
    logic [BUF_W-1:0]       buf_corr;
    logic [2:0]             kind_reg;
    logic [7:0]             cmd_reg;
    logic [7:0]             char_reg;
    logic [DIG_W-1:0]       ndig_reg;
    logic                   neg_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;
    logic                   m_last_reg, m_last_next;

    logic                   out_free;
    logic                   push;
    logic [7:0]             push_byte;
    logic                   push_data;
    logic                   push_last;
    logic                   kind_numeric;
    logic                   kind_plain_num;
    logic                   conv_bit;

    assign in_line   = s_axis_tdata[1:0];
    assign in_column = s_axis_tdata[7:2];
    assign in_value  = s_axis_tdata[23:8];
    assign in_digits = s_axis_tdata[28:24];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign val_w    = VALUE_WIDTH'(32'(in_value));
    assign val_neg  = val_w[VALUE_WIDTH-1];
    assign cmd_byte = CMD_SET_ADDR | ({2'b00, in_column} + 8'hFF
                      + ((in_line != LINE_TOP) ? LINE2_OFFSET : 8'h00));
    assign ndig_in  = (in_digits > 5'(MAX_DIGITS)) ? DIG_W'(MAX_DIGITS) : DIG_W'(in_digits);

    assign kind_plain_num = (kind_reg == KIND_UDEC) || (kind_reg == KIND_HEX)
                            || (kind_reg == KIND_BIN);
    assign kind_numeric   = kind_plain_num || (kind_reg == KIND_SDEC);

    assign out_free = !m_valid_reg || m_axis_tready;
    assign conv_bit = mag_reg[VALUE_WIDTH-1];

    always_comb
    begin
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            buf_corr[4*j +: 4] = (buf_reg[4*j +: 4] >= 4'd5) ? buf_reg[4*j +: 4] + 4'd3
                                                            : buf_reg[4*j +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        buf_reg    <= buf_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        if (s_acc)
        begin
            kind_reg <= s_axis_tuser;
            cmd_reg  <= cmd_byte;
            char_reg <= in_value[7:0];
            ndig_reg <= ndig_in;
            neg_reg  <= (s_axis_tuser == KIND_SDEC) && val_neg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        buf_next   = buf_reg;
        push       = 1'b0;
        push_byte  = '0;
        push_data  = 1'b0;
        push_last  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    mag_next   = ((s_axis_tuser == KIND_SDEC) && val_neg)
                                 ? VALUE_WIDTH'(0) - val_w : val_w;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_byte = cmd_reg;
                    push_last = !kind_numeric && (kind_reg != KIND_CHAR)
                                || (kind_plain_num && (ndig_reg == '0));
                    buf_next  = '0;
                    cnt_next  = '0;
                    priority if (kind_reg == KIND_CHAR)
                        state_next = ST_CHAR;
                    else if (kind_reg == KIND_SDEC)
                        state_next = ST_SIGN;
                    else if (kind_plain_num && (ndig_reg != '0))
                        state_next = ST_CONV;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_byte  = char_reg;
                    push_data  = 1'b1;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_byte  = neg_reg ? ASCII_MINUS : ASCII_PLUS;
                    push_data  = 1'b1;
                    push_last  = (ndig_reg == '0);
                    state_next = (ndig_reg == '0) ? ST_IDLE : ST_CONV;
                end
            end
            ST_CONV:
            begin
                mag_next = mag_reg << 1;
                priority if ((kind_reg == KIND_UDEC) || (kind_reg == KIND_SDEC))
                    buf_next = (buf_corr << 1) | BUF_W'(conv_bit);
                else if (kind_reg == KIND_HEX)
                    buf_next = (buf_reg << 1) | BUF_W'(conv_bit);
                else
                    buf_next = (buf_reg << 4) | BUF_W'(conv_bit);
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    cnt_next   = CNT_W'(MAX_DIGITS) - CNT_W'(ndig_reg);
                    state_next = ST_ALIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ALIGN:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(ndig_reg);
                    state_next = ST_EMIT;
                end
                else
                begin
                    buf_next = buf_reg << 4;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_byte = digit_to_ascii(buf_reg[BUF_W-1 -: 4]);
                    push_data = 1'b1;
                    push_last = (cnt_reg == CNT_W'(1));
                    buf_next  = buf_reg << 4;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (push)
        begin
            m_valid_next = 1'b1;
            m_data_next  = push_byte;
            m_user_next  = push_data;
            m_last_next  = push_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

>>> src/clnf_checker.sv
// ----------------------------------------------------------------------------
// clnf_checker
// Port-level checks for the character LCD number formatter.
// ----------------------------------------------------------------------------
module clnf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic       s_acc;
    logic       m_acc;
    logic       first_reg, first_next;
    logic [1:0] pend_reg, pend_next;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        first_next = m_acc ? m_axis_tlast : first_reg;
        pend_next  = pend_reg + {1'b0, s_acc} - {1'b0, m_acc && m_axis_tlast};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            pend_reg  <= '0;
        end
        else
        begin
            first_reg <= first_next;
            pend_reg  <= pend_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_axis_tready)
        else $error("request word accepted while a request was in progress");

    a_first_is_command: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && first_reg) |-> (!m_axis_tuser && m_axis_tdata[7]))
        else $error("request does not open with a cursor command");

    a_no_orphan_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pend_reg != 2'd0))
        else $error("output word without a pending request");

    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled output word changed");

endmodule

bind char_lcd_number_formatter clnf_checker u_clnf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
